// ===== design/julia_set_membership_test_assert.svh =====
// Assertion macros for the Julia set membership test.
// ASSERT_IMPLIES checks a consequent in the same cycle.
// ASSERT_NEXT checks a consequent in the following cycle.
`ifndef JULIA_SET_MEMBERSHIP_TEST_ASSERT_SVH
`define JULIA_SET_MEMBERSHIP_TEST_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/jset_pkg.sv =====
package jset_pkg;

    // Q4.28 coordinates
    localparam int CW    = 32;
    localparam int FB    = 28;
    localparam int PW    = 2 * CW;
    localparam int TW    = PW - FB;
    localparam int SW    = TW + 1;
    localparam int CNT_W = 8;
    localparam int RW    = 32;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [CW-1:0]        t_umag;
    typedef logic [PW-1:0]        t_prod;
    typedef logic [CNT_W-1:0]     t_count;

    localparam t_coord SMAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord SMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [TW-1:0] SMAX_T = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};

    // Register reset values: c = -1.0, radius squared = 4.0, 100 iterations
    localparam t_coord         CR_RESET     = -(t_coord'(1) <<< FB);
    localparam t_coord         CI_RESET     = '0;
    localparam logic [RW-1:0]  RADIUS_RESET = RW'(4) << FB;
    localparam t_count         ITER_RESET   = t_count'(100);

    typedef enum logic [1:0] {
        CFG_CONST_REAL = 2'd0,
        CFG_CONST_IMAG = 2'd1,
        CFG_RADIUS_SQ  = 2'd2,
        CFG_ITER_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] start_real;
        logic signed [31:0] start_imag;
    } t_in_item;

    typedef struct packed {
        logic       inside_res;
        logic [7:0] escape_step;
    } t_out_item;

    // Control that travels with each item around the iteration ring
    typedef struct packed {
        logic   valid;
        t_count count;
        logic   esc;
        t_count step;
    } t_tag;

    typedef struct packed {
        t_coord        const_real;
        t_coord        const_imag;
        logic [RW-1:0] radius_sq;
        t_count        limit;
    } t_cfg;

    function automatic t_umag mag(input t_coord a);
        t_umag r;
        if (a[CW-1]) begin
            r = t_umag'(~a) + t_umag'(1);
        end else begin
            r = t_umag'(a);
        end
        return r;
    endfunction

    // Truncate a magnitude product by FB bits and saturate to signed range
    function automatic t_coord sat_prod(input t_prod p, input logic neg);
        logic [TW-1:0] m;
        t_coord        r;
        m = p[PW-1:FB];
        if (m > SMAX_T) begin
            r = neg ? SMIN : SMAX;
        end else if (neg) begin
            r = -t_coord'(m[CW-1:0]);
        end else begin
            r = t_coord'(m[CW-1:0]);
        end
        return r;
    endfunction

    function automatic t_coord sat_add(input t_coord a, input t_coord b);
        logic signed [CW:0] s;
        t_coord             r;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1]) begin
            r = s[CW] ? SMIN : SMAX;
        end else begin
            r = s[CW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/jset_cmul.sv =====
// Complex square and add: z*z + c over three register stages.
module jset_cmul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  jset_pkg::t_coord   i_x,
    input  jset_pkg::t_coord   i_y,
    input  jset_pkg::t_tag     i_tag,
    input  jset_pkg::t_cfg     i_cfg,
    output jset_pkg::t_coord   o_x,
    output jset_pkg::t_coord   o_y,
    output jset_pkg::t_tag     o_tag
);

    jset_pkg::t_umag  mx;
    jset_pkg::t_umag  my;
    jset_pkg::t_prod  r1_pxx;
    jset_pkg::t_prod  r1_pyy;
    jset_pkg::t_prod  r1_pxy;
    logic             r1_neg;
    jset_pkg::t_tag   r1_tag;
    jset_pkg::t_coord r2_diff;
    jset_pkg::t_coord r2_xy;
    jset_pkg::t_tag   r2_tag;
    jset_pkg::t_coord r3_x;
    jset_pkg::t_coord r3_y;
    jset_pkg::t_tag   r3_tag;
    jset_pkg::t_coord n_diff;
    jset_pkg::t_coord n_xy;
    jset_pkg::t_coord n_x;
    jset_pkg::t_coord n_y;

    assign mx = jset_pkg::mag(i_x);
    assign my = jset_pkg::mag(i_y);

    // Stage two: truncate products; squares are nonnegative so the difference fits
    always_comb begin
        n_diff = jset_pkg::sat_prod(r1_pxx, 1'b0) - jset_pkg::sat_prod(r1_pyy, 1'b0);
        n_xy   = jset_pkg::sat_prod(r1_pxy, r1_neg);
    end

    // Stage three: add the constant with saturation
    always_comb begin
        n_x = jset_pkg::sat_add(r2_diff, i_cfg.const_real);
        n_y = jset_pkg::sat_add(jset_pkg::sat_add(r2_xy, r2_xy), i_cfg.const_imag);
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
        end else if (i_en) begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
        end
    end

    // Advance data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pxx  <= jset_pkg::t_prod'(mx) * jset_pkg::t_prod'(mx);
            r1_pyy  <= jset_pkg::t_prod'(my) * jset_pkg::t_prod'(my);
            r1_pxy  <= jset_pkg::t_prod'(mx) * jset_pkg::t_prod'(my);
            r1_neg  <= i_x[jset_pkg::CW-1] ^ i_y[jset_pkg::CW-1];
            r2_diff <= n_diff;
            r2_xy   <= n_xy;
            r3_x    <= n_x;
            r3_y    <= n_y;
        end
    end

    assign o_x   = r3_x;
    assign o_y   = r3_y;
    assign o_tag = r3_tag;

endmodule

// ===== design/jset_norm.sv =====
// Squared magnitude of the new z, escape compare and step bookkeeping.
module jset_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  jset_pkg::t_coord   i_x,
    input  jset_pkg::t_coord   i_y,
    input  jset_pkg::t_tag     i_tag,
    input  jset_pkg::t_cfg     i_cfg,
    output jset_pkg::t_coord   o_x,
    output jset_pkg::t_coord   o_y,
    output jset_pkg::t_tag     o_tag
);

    jset_pkg::t_umag           mx;
    jset_pkg::t_umag           my;
    jset_pkg::t_prod           r4_psx;
    jset_pkg::t_prod           r4_psy;
    jset_pkg::t_coord          r4_x;
    jset_pkg::t_coord          r4_y;
    jset_pkg::t_tag            r4_tag;
    jset_pkg::t_coord          r5_x;
    jset_pkg::t_coord          r5_y;
    jset_pkg::t_tag            r5_tag;
    logic [jset_pkg::SW-1:0]   sum;
    logic                      gt;
    logic [jset_pkg::CNT_W:0]  k;
    logic                      active;
    jset_pkg::t_tag            n_tag;

    assign mx = jset_pkg::mag(i_x);
    assign my = jset_pkg::mag(i_y);

    // Compare |z|^2 with the radius; mark the first escape within the limit
    always_comb begin
        sum    = {1'b0, r4_psx[jset_pkg::PW-1:jset_pkg::FB]}
               + {1'b0, r4_psy[jset_pkg::PW-1:jset_pkg::FB]};
        gt     = sum > jset_pkg::SW'(i_cfg.radius_sq);
        k      = {1'b0, r4_tag.count} + 1'b1;
        active = !r4_tag.esc && (r4_tag.count < i_cfg.limit);
        n_tag  = r4_tag;
        n_tag.count = k[jset_pkg::CNT_W-1:0];
        if (active && gt) begin
            n_tag.esc  = 1'b1;
            n_tag.step = k[jset_pkg::CNT_W-1:0];
        end
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_tag <= '0;
            r5_tag <= '0;
        end else if (i_en) begin
            r4_tag <= i_tag;
            r5_tag <= n_tag;
        end
    end

    // Advance data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_psx <= jset_pkg::t_prod'(mx) * jset_pkg::t_prod'(mx);
            r4_psy <= jset_pkg::t_prod'(my) * jset_pkg::t_prod'(my);
            r4_x   <= i_x;
            r4_y   <= i_y;
            r5_x   <= r4_x;
            r5_y   <= r4_y;
        end
    end

    assign o_x   = r5_x;
    assign o_y   = r5_y;
    assign o_tag = r5_tag;

endmodule

// ===== design/julia_set_membership_test.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_item  (start_real, start_imag)
// out       output     o_out_valid / i_out_ready  o_out_item (inside_res, escape_step)
// cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One iteration is one pass around a ring of five register stages; each item
// makes iteration_limit passes (one pass when the limit is zero), and on the last
// pass the output register takes the place of stage one.
// Up to five items share the ring, one per stage; a new item enters only when
// the ring's slot at stage one holds no recirculating item and the ring is not frozen.
// Reset is synchronous, active low, clears valid bits and loads register defaults.
// A finished item waiting on a full output register freezes the whole ring.
module julia_set_membership_test (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  jset_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output jset_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

`include "julia_set_membership_test_assert.svh"

    jset_pkg::t_cfg      r_cfg;
    jset_pkg::t_cfg_idx  cfg_idx;
    jset_pkg::t_coord    s1_x;
    jset_pkg::t_coord    s1_y;
    jset_pkg::t_tag      s1_tag;
    jset_pkg::t_coord    m_x;
    jset_pkg::t_coord    m_y;
    jset_pkg::t_tag      m_tag;
    jset_pkg::t_coord    e_x;
    jset_pkg::t_coord    e_y;
    jset_pkg::t_tag      e_tag;
    logic                done;
    logic                fb_busy;
    logic                exit_v;
    logic                advance;
    logic                r_out_valid;
    jset_pkg::t_out_item r_out;
    jset_pkg::t_out_item n_out;

    assign cfg_idx = jset_pkg::t_cfg_idx'(i_cfg_idx);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.const_real <= jset_pkg::CR_RESET;
            r_cfg.const_imag <= jset_pkg::CI_RESET;
            r_cfg.radius_sq  <= jset_pkg::RADIUS_RESET;
            r_cfg.limit      <= jset_pkg::ITER_RESET;
        end else if (i_cfg_we) begin
            case (cfg_idx)
                jset_pkg::CFG_CONST_REAL: r_cfg.const_real <= jset_pkg::t_coord'(i_cfg_data);
                jset_pkg::CFG_CONST_IMAG: r_cfg.const_imag <= jset_pkg::t_coord'(i_cfg_data);
                jset_pkg::CFG_RADIUS_SQ:  r_cfg.radius_sq  <= i_cfg_data;
                jset_pkg::CFG_ITER_LIMIT: r_cfg.limit      <= i_cfg_data[jset_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Ring control: an item leaves after its last pass, else it recirculates
    always_comb begin
        done       = e_tag.count >= r_cfg.limit;
        exit_v     = e_tag.valid && done;
        fb_busy    = e_tag.valid && !done;
        advance    = !(exit_v && r_out_valid && !i_out_ready);
        o_in_ready = advance && !fb_busy;
    end

    // Stage one input: recirculated item or a new one
    always_comb begin
        if (fb_busy) begin
            s1_x   = e_x;
            s1_y   = e_y;
            s1_tag = e_tag;
        end else begin
            s1_x         = jset_pkg::t_coord'(i_in_item.start_real);
            s1_y         = jset_pkg::t_coord'(i_in_item.start_imag);
            s1_tag       = '0;
            s1_tag.valid = i_in_valid;
        end
    end

    jset_cmul u_cmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_x     (s1_x),
        .i_y     (s1_y),
        .i_tag   (s1_tag),
        .i_cfg   (r_cfg),
        .o_x     (m_x),
        .o_y     (m_y),
        .o_tag   (m_tag)
    );

    jset_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_x     (m_x),
        .i_y     (m_y),
        .i_tag   (m_tag),
        .i_cfg   (r_cfg),
        .o_x     (e_x),
        .o_y     (e_y),
        .o_tag   (e_tag)
    );

    // Form the result of a finished item
    always_comb begin
        n_out.inside_res  = !e_tag.esc;
        n_out.escape_step = e_tag.esc ? e_tag.step : r_cfg.limit;
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && exit_v) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && exit_v) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ASSERT_IMPLIES(a_no_entry_on_busy_slot, i_clk, i_rst_n, i_in_valid && o_in_ready, !fb_busy)
    `ASSERT_IMPLIES(a_step_within_limit, i_clk, i_rst_n, o_out_valid, o_out_item.escape_step <= r_cfg.limit)
    `ASSERT_IMPLIES(a_inside_reports_limit, i_clk, i_rst_n, o_out_valid && o_out_item.inside_res, o_out_item.escape_step == r_cfg.limit)
    `ASSERT_IMPLIES(a_escape_step_nonzero, i_clk, i_rst_n, e_tag.valid && e_tag.esc, e_tag.step != '0)
    `ASSERT_NEXT(a_exit_loads_output, i_clk, i_rst_n, advance && exit_v, r_out_valid)

endmodule
